FILE: design/assert_macros.svh
// Assertion macros for the checker file sgbs_checker.sv.
// Clock clk_i and active-low reset rst_ni are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SGBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// when trig holds, cons must hold in the next cycle
`define SGBS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sgbs_pkg.sv
// Package for the sphere grid bilinear sampler: types, codes, constants.
// Holds the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package sgbs_pkg;

  localparam int MAX_ROWS_DEF     = 64;
  localparam int MAX_COLS_DEF     = 128;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CW    = 36;  // CORDIC datapath width, covers gain and pre-rotation
  localparam int CFG_W = 8;

  localparam logic [6:0] ROWS_RST = 7'd64;
  localparam logic [7:0] COLS_RST = 8'd128;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_LAT_ROWS = 1'b0;
  localparam logic REG_LON_COLS = 1'b1;

  typedef enum logic [1:0] {
    STAT_MISS    = 2'd0,
    STAT_BLEND   = 2'd1,
    STAT_NEAREST = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ANG, S_LAT, S_SCALE, S_INDEX, S_ADDR, S_READ,
    S_CHECK, S_NEAR_RD, S_NEAR_WT, S_ROW, S_SUM, S_COL, S_RND
  } state_e;

  typedef struct packed {
    logic               mode;
    logic        [12:0] cell_index;
    logic               cell_valid;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } res_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } cell_t;

  // atan(2^-i) in binary turns, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: design/sphere_grid_bilinear_sampler.sv
// Sphere grid bilinear sampler, top level.
// Uses sgbs_pkg, sgbs_ram, sgbs_cordic and sgbs_isqrt.
`timescale 1ns / 1ps
// Usage:
//   Command channel: an item transfers on a clock edge with start_i high and
//   busy_o low. mode 0 writes one grid cell (valid mark plus point) into the
//   cell store; mode 1 queries a direction.
//   A write keeps busy_o low and gives no result; indices past rows*cols are dropped.
//   A query raises busy_o for its whole run and then presents one result on
//   res_o for exactly one cycle with valid_o high; the receiver has no way to
//   hold it, so it must take it in that cycle.
//   A query runs the bit-serial square root alongside the longitude CORDIC,
//   then the latitude CORDIC on the shared unit, then reads the four
//   neighbour cells from the cell store. The blend path then does a
//   multiply-add pass per coordinate; the nearest-cell or miss path reads
//   one more cell instead, and with rows or columns zero a miss follows
//   the reads directly.
//   One query is in flight at a time; the next command can go in the result cycle.
//   Configuration: cfg_we_i writes lat_rows (index 0) or lon_cols (index 1)
//   from cfg_data_i; write only while busy_o is low and no result is due.
//   Reset: after rst_ni releases, a clearing pass zeroes the valid marks of
//   all MAX_ROWS*MAX_COLS cells, one per cycle; busy_o is high meanwhile.
module sphere_grid_bilinear_sampler #(
  parameter int MAX_ROWS     = sgbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = sgbs_pkg::MAX_COLS_DEF,
  parameter int CORDIC_STEPS = sgbs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  sgbs_pkg::req_t             req_i,
  output logic                       busy_o,
  output logic                       valid_o,
  output sgbs_pkg::res_t             res_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [sgbs_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CELL_W = $bits(sgbs_pkg::cell_t);
  localparam int CW     = sgbs_pkg::CW;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [2:0]    RD_LAST  = 3'd4;

  sgbs_pkg::state_e state_q, state_d;

  logic [6:0] rows_q;
  logic [7:0] cols_q;
  logic [AW-1:0] clr_q;
  logic signed [15:0] dz_q;
  logic [31:0] lon_q;
  logic [24:0] blat_q, blon_q;
  logic [6:0] la_lo_q, la_hi_q, la_nr_q;
  logic [7:0] lo_lo_q, lo_hi_q, lo_nr_q;
  logic [15:0] idx_q [5];
  logic [2:0] rd_cnt_q;
  sgbs_pkg::cell_t nb_q [4];
  logic [3:0] nb_ok_q;
  logic [1:0] comp_q;
  logic signed [49:0] r0p_q, r1p_q, r0_q;
  logic signed [50:0] dr_q;
  logic signed [67:0] prod_q;
  logic valid_q, valid_d;
  sgbs_pkg::res_t res_q;

  // memory and unit hookup
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  sgbs_pkg::cell_t rd_cell;
  logic c_start, c_busy, s_start, s_busy;
  logic signed [CW-1:0] c_y, c_x;
  logic [31:0] c_ang, s_root;

  logic accept, wr_ok, cfg_zero;
  logic signed [31:0] sqx, sqy;
  logic [31:0] sq;

  assign accept   = start_i && (state_q == sgbs_pkg::S_IDLE);
  assign cfg_zero = (rows_q == '0) || (cols_q == '0);
  assign sqx      = req_i.dir_x * req_i.dir_x;
  assign sqy      = req_i.dir_y * req_i.dir_y;
  assign sq       = 32'(sqx) + 32'(sqy);
  assign wr_ok    = (15'(req_i.cell_index) < (15'(rows_q) * 15'(cols_q)))
                 && (32'(req_i.cell_index) < 32'(DEPTH));
  assign rd_cell  = ram_rdata;
  assign valid_d  = ((state_q == sgbs_pkg::S_CHECK) && cfg_zero)
                 || (state_q == sgbs_pkg::S_NEAR_WT)
                 || ((state_q == sgbs_pkg::S_RND) && (comp_q == 2'd2));

  sgbs_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  sgbs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(c_start),
    .y_i    (c_y),
    .x_i    (c_x),
    .busy_o (c_busy),
    .ang_o  (c_ang)
  );

  sgbs_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(s_start),
    .sq_i   (sq),
    .busy_o (s_busy),
    .root_o (s_root)
  );

  function automatic logic [6:0] clamp_row(input logic [9:0] v, input logic [6:0] rmax);
    return (v > 10'(rmax)) ? rmax : v[6:0];
  endfunction

  function automatic logic in_range(input logic [15:0] i);
    return 32'(i) < 32'(DEPTH);
  endfunction

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sgbs_pkg::S_CLEAR:   if (clr_q == CLR_LAST) state_d = sgbs_pkg::S_IDLE;
      sgbs_pkg::S_IDLE:    if (accept && (req_i.mode == sgbs_pkg::MODE_QUERY)) begin
        state_d = sgbs_pkg::S_ANG;
      end
      sgbs_pkg::S_ANG:     if (!c_busy && !s_busy) state_d = sgbs_pkg::S_LAT;
      sgbs_pkg::S_LAT:     if (!c_busy) state_d = sgbs_pkg::S_SCALE;
      sgbs_pkg::S_SCALE:   state_d = sgbs_pkg::S_INDEX;
      sgbs_pkg::S_INDEX:   state_d = sgbs_pkg::S_ADDR;
      sgbs_pkg::S_ADDR:    state_d = sgbs_pkg::S_READ;
      sgbs_pkg::S_READ:    if (rd_cnt_q == RD_LAST) state_d = sgbs_pkg::S_CHECK;
      sgbs_pkg::S_CHECK: begin
        if (cfg_zero) begin
          state_d = sgbs_pkg::S_IDLE;
        end else if (&nb_ok_q) begin
          state_d = sgbs_pkg::S_ROW;
        end else begin
          state_d = sgbs_pkg::S_NEAR_RD;
        end
      end
      sgbs_pkg::S_NEAR_RD: state_d = sgbs_pkg::S_NEAR_WT;
      sgbs_pkg::S_NEAR_WT: state_d = sgbs_pkg::S_IDLE;
      sgbs_pkg::S_ROW:     state_d = sgbs_pkg::S_SUM;
      sgbs_pkg::S_SUM:     state_d = sgbs_pkg::S_COL;
      sgbs_pkg::S_COL:     state_d = sgbs_pkg::S_RND;
      sgbs_pkg::S_RND:     state_d = (comp_q == 2'd2) ? sgbs_pkg::S_IDLE : sgbs_pkg::S_ROW;
      default:             state_d = sgbs_pkg::S_IDLE;
    endcase
  end

  // ---------------- outputs toward memory and units
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(idx_q[rd_cnt_q]);
    ram_wdata = '0;
    c_start   = 1'b0;
    c_y       = {{(CW-32){req_i.dir_y[15]}}, req_i.dir_y, 16'h0000};
    c_x       = {{(CW-32){req_i.dir_x[15]}}, req_i.dir_x, 16'h0000};
    s_start   = 1'b0;
    case (state_q)
      sgbs_pkg::S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      sgbs_pkg::S_IDLE: begin
        ram_addr  = AW'(req_i.cell_index);
        ram_wdata = {req_i.cell_valid, req_i.cell_x, req_i.cell_y, req_i.cell_z};
        ram_we    = accept && (req_i.mode == sgbs_pkg::MODE_WRITE) && wr_ok;
        c_start   = accept && (req_i.mode == sgbs_pkg::MODE_QUERY);
        s_start   = c_start;
      end
      sgbs_pkg::S_ANG: begin
        c_y     = {{(CW-32){dz_q[15]}}, dz_q, 16'h0000};
        c_x     = CW'(s_root);
        c_start = !c_busy && !s_busy;
      end
      sgbs_pkg::S_NEAR_RD: ram_addr = AW'(idx_q[4]);
      default: ;
    endcase
  end

  // ---------------- datapath helpers
  logic signed [33:0] latx;
  logic [31:0] latu;
  logic [38:0] plat;
  logic [39:0] plon;
  logic [9:0]  vlat, vlatn, vlon, vlonn;
  logic [25:0] blatn, blonn;
  logic [6:0]  rmax;
  logic [7:0]  cmax, lo_lo_c;
  logic signed [31:0] a00, a01, a10, a11;
  logic signed [32:0] d0, d1;
  logic signed [16:0] wlon, wlat;
  logic signed [49:0] r0_c, r1_c;
  logic signed [67:0] s_c;
  logic [31:0] pt;

  always_comb begin
    latx = {{2{c_ang[31]}}, c_ang} + 34'sh0_4000_0000;
    if (latx[33]) begin
      latu = '0;
    end else if (latx > 34'sh0_8000_0000) begin
      latu = 32'h80000000;
    end else begin
      latu = latx[31:0];
    end
    plat = 39'(latu) * 39'(rows_q);
    plon = 40'(lon_q) * 40'(cols_q);

    rmax    = rows_q - 1'b1;
    cmax    = cols_q - 1'b1;
    blatn   = 26'(blat_q) + 26'd32768;
    blonn   = 26'(blon_q) + 26'd32768;
    vlat    = 10'(blat_q[24:16]);
    vlatn   = blatn[25:16];
    vlon    = 10'(blon_q[24:16]);
    vlonn   = blonn[25:16];
    lo_lo_c = (vlon == '0) ? cmax : 8'(vlon - 1'b1);

    case (comp_q)
      2'd0: begin
        a00 = nb_q[0].px; a01 = nb_q[1].px; a10 = nb_q[2].px; a11 = nb_q[3].px;
      end
      2'd1: begin
        a00 = nb_q[0].py; a01 = nb_q[1].py; a10 = nb_q[2].py; a11 = nb_q[3].py;
      end
      default: begin
        a00 = nb_q[0].pz; a01 = nb_q[1].pz; a10 = nb_q[2].pz; a11 = nb_q[3].pz;
      end
    endcase
    wlon = {1'b0, blon_q[15:0]};
    wlat = {1'b0, blat_q[15:0]};
    // a0*(1-t)+a1*t written as a0*1.0 + (a1-a0)*t, exact in Q16
    d0   = 33'(a01) - 33'(a00);
    d1   = 33'(a11) - 33'(a10);
    r0_c = (50'(a00) <<< 16) + r0p_q;
    r1_c = (50'(a10) <<< 16) + r1p_q;
    s_c  = (68'(r0_q) <<< 16) + prod_q + 68'sh0_8000_0000;  // round half up
    pt   = s_c[63:32];
  end

  // ---------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sgbs_pkg::S_CLEAR;
      rows_q   <= sgbs_pkg::ROWS_RST;
      cols_q   <= sgbs_pkg::COLS_RST;
      clr_q    <= '0;
      rd_cnt_q <= '0;
      comp_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sgbs_pkg::REG_LAT_ROWS: rows_q <= cfg_data_i[6:0];
          sgbs_pkg::REG_LON_COLS: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        sgbs_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
        sgbs_pkg::S_ADDR:  rd_cnt_q <= '0;
        sgbs_pkg::S_READ:  if (rd_cnt_q != RD_LAST) rd_cnt_q <= rd_cnt_q + 1'b1;
        sgbs_pkg::S_CHECK: comp_q <= '0;
        sgbs_pkg::S_RND:   comp_q <= comp_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      sgbs_pkg::S_IDLE: dz_q <= req_i.dir_z;
      sgbs_pkg::S_ANG:  lon_q <= c_ang;
      sgbs_pkg::S_SCALE: begin
        blat_q <= 25'(plat[38:15]) + 25'd32768;
        blon_q <= 25'(plon[39:16]) + 25'd32768;
      end
      sgbs_pkg::S_INDEX: begin
        la_hi_q <= clamp_row(vlat, rmax);
        la_lo_q <= (vlat == '0) ? 7'd0 : clamp_row(vlat - 1'b1, rmax);
        la_nr_q <= (vlatn == '0) ? 7'd0 : clamp_row(vlatn - 1'b1, rmax);
        lo_lo_q <= lo_lo_c;
        lo_hi_q <= (lo_lo_c == cmax) ? 8'd0 : lo_lo_c + 1'b1;
        if (vlonn == '0) begin
          lo_nr_q <= cmax;
        end else if ((vlonn - 1'b1) == 10'(cols_q)) begin
          lo_nr_q <= 8'd0;  // wrapped past the seam
        end else begin
          lo_nr_q <= 8'(vlonn - 1'b1);
        end
      end
      sgbs_pkg::S_ADDR: begin
        idx_q[0] <= 16'(la_lo_q) * 16'(cols_q) + 16'(lo_lo_q);
        idx_q[1] <= 16'(la_lo_q) * 16'(cols_q) + 16'(lo_hi_q);
        idx_q[2] <= 16'(la_hi_q) * 16'(cols_q) + 16'(lo_lo_q);
        idx_q[3] <= 16'(la_hi_q) * 16'(cols_q) + 16'(lo_hi_q);
        idx_q[4] <= 16'(la_nr_q) * 16'(cols_q) + 16'(lo_nr_q);
      end
      sgbs_pkg::S_READ: begin
        // read data belongs to the address of the previous cycle
        if (rd_cnt_q != '0) begin
          nb_q[2'(rd_cnt_q - 1'b1)]    <= rd_cell;
          nb_ok_q[2'(rd_cnt_q - 1'b1)] <= rd_cell.ok && in_range(idx_q[rd_cnt_q - 1'b1]);
        end
      end
      sgbs_pkg::S_CHECK: begin
        res_q <= '{status: sgbs_pkg::STAT_MISS, point_x: '0, point_y: '0, point_z: '0};
      end
      sgbs_pkg::S_NEAR_WT: begin
        if (rd_cell.ok && in_range(idx_q[4])) begin
          res_q <= '{status: sgbs_pkg::STAT_NEAREST, point_x: rd_cell.px,
                     point_y: rd_cell.py, point_z: rd_cell.pz};
        end
      end
      sgbs_pkg::S_ROW: begin
        r0p_q <= d0 * wlon;
        r1p_q <= d1 * wlon;
      end
      sgbs_pkg::S_SUM: begin
        r0_q <= r0_c;
        dr_q <= 51'(r1_c) - 51'(r0_c);
      end
      sgbs_pkg::S_COL: prod_q <= dr_q * wlat;
      sgbs_pkg::S_RND: begin
        res_q.status <= sgbs_pkg::STAT_BLEND;
        case (comp_q)
          2'd0:    res_q.point_x <= pt;
          2'd1:    res_q.point_y <= pt;
          default: res_q.point_z <= pt;
        endcase
      end
      default: ;
    endcase
  end

  assign busy_o  = (state_q != sgbs_pkg::S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: design/sgbs_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sgbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sgbs_cordic.sv
// Iterative vectoring CORDIC, one micro-rotation per cycle, returns atan2(y, x)
// in binary turns. Uses sgbs_pkg (datapath width, arctangent table).
`timescale 1ns / 1ps
module sgbs_cordic #(
  parameter int STEPS = sgbs_pkg::CORDIC_STEPS_DEF,
  localparam int CNT_W = $clog2(STEPS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [sgbs_pkg::CW-1:0] y_i,
  input  logic signed [sgbs_pkg::CW-1:0] x_i,
  output logic                          busy_o,
  output logic [31:0]                   ang_o
);

  logic                          run_q;
  logic [CNT_W-1:0]              cnt_q;
  logic signed [sgbs_pkg::CW-1:0] x_q, y_q, xs, ys;
  logic [31:0]                   ang_q;
  logic                          zero_q;
  logic                          last;

  assign last = (cnt_q == CNT_W'(STEPS));
  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q && last) begin
      run_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i[sgbs_pkg::CW-1]) begin
        // left half plane: rotate by half a turn first
        x_q   <= -x_i;
        y_q   <= -y_i;
        ang_q <= 32'h80000000;
      end else begin
        x_q   <= x_i;
        y_q   <= y_i;
        ang_q <= '0;
      end
    end else if (run_q && !last) begin
      if (!y_q[sgbs_pkg::CW-1] && (y_q != '0)) begin
        x_q   <= x_q + ys;
        y_q   <= y_q - xs;
        ang_q <= ang_q + sgbs_pkg::atan_turn(5'(cnt_q));
      end else begin
        x_q   <= x_q - ys;
        y_q   <= y_q + xs;
        ang_q <= ang_q - sgbs_pkg::atan_turn(5'(cnt_q));
      end
    end
  end

  assign busy_o = run_q;
  assign ang_o  = zero_q ? 32'h0 : ang_q;

endmodule

FILE: design/sgbs_isqrt.sv
// Bit-serial integer square root of (sq_i << 32), one result bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps
module sgbs_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] sq_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic        run_q;
  logic [63:0] n_q, res_q, bit_q, trial;
  logic        ge;

  assign trial = res_q + bit_q;
  assign ge    = (n_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (run_q && (bit_q == '0)) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {sq_i, 32'h0};
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (run_q && (bit_q != '0)) begin
      if (ge) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = run_q;
  assign root_o = res_q[31:0];

endmodule

FILE: design/sgbs_checker.sv
// Port-level checker for the sphere grid bilinear sampler, bound to the top.
// Uses sgbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sgbs_port_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input sgbs_pkg::req_t req_i,
  input logic           busy_o,
  input logic           valid_o,
  input sgbs_pkg::res_t res_o
);

  `SGBS_ASSERT(a_miss_zero, (valid_o && res_o.status == sgbs_pkg::STAT_MISS) |-> (res_o.point_x == 0 && res_o.point_y == 0 && res_o.point_z == 0), "miss result carries a point")
  `SGBS_ASSERT_NEXT(a_query_busy, start_i && !busy_o && req_i.mode == sgbs_pkg::MODE_QUERY, busy_o, "query transfer did not start work")
  `SGBS_ASSERT_NEXT(a_write_quiet, start_i && !busy_o && req_i.mode == sgbs_pkg::MODE_WRITE, !busy_o && !valid_o, "write produced work or a result")
  `SGBS_ASSERT_NEXT(a_one_pulse, valid_o, !valid_o, "result strobe longer than one cycle")

endmodule

bind sphere_grid_bilinear_sampler sgbs_port_checker u_sgbs_checker (.*);
